// ----- rtl/core/slcnt_pkg.sv -----
package slcnt_pkg;

    localparam int LIST_DEPTH = 1024;
    localparam int ID_WIDTH   = 20;

    localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int ENTRY_W = ID_WIDTH + 1;

    localparam int IN_ID_W   = 20;
    localparam int TALLY_W   = 32;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 200;
    localparam int ACTION_W  = 2;

    localparam int T_TOTAL = 0;
    localparam int T_REM   = 1;
    localparam int T_ADD0  = 2;
    localparam int T_ADD1  = 3;
    localparam int T_REM0  = 4;
    localparam int T_REM1  = 5;
    localparam int T_NUM   = 6;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_OLD = 2'd0,
        ACT_LOAD_NEW = 2'd1,
        ACT_MERGE    = 2'd2,
        ACT_CLEAR    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_old;
        logic load_new;
        logic merge_start;
        logic walk;
        logic walk_end;
        logic clear;
        logic publish;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_full;
    } status_t;

    function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v,
                                                   input logic en);
        logic [TALLY_W-1:0] r;
        r = v;
        if (en && (v != TALLY_MAX)) begin
            r = v + 1'b1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/slcnt_ctrl.sv -----
module slcnt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  slcnt_pkg::action_t  action,
    output logic                s_tready,
    output slcnt_pkg::cmd_t     cmd,
    input  slcnt_pkg::status_t  status
);
    import slcnt_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && action == ACT_MERGE) begin
                    state_next = ST_WALK;
                end else if (accept && action == ACT_CLEAR) begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK: begin
                if (status.walk_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!status.out_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready         = 1'b1;
                cmd.load_old     = accept && (action == ACT_LOAD_OLD);
                cmd.load_new     = accept && (action == ACT_LOAD_NEW);
                cmd.merge_start  = accept && (action == ACT_MERGE);
                cmd.clear        = accept && (action == ACT_CLEAR);
            end
            ST_WALK: begin
                cmd.walk     = !status.walk_done;
                cmd.walk_end = status.walk_done;
            end
            ST_DONE: begin
                cmd.publish = !status.out_full;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/slcnt_datapath.sv -----
module slcnt_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [slcnt_pkg::IN_ID_W-1:0]       instance_id,
    input  logic                                group_one,
    input  slcnt_pkg::cmd_t                     cmd,
    output slcnt_pkg::status_t                  status,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [slcnt_pkg::M_TDATA_W-1:0]     m_tdata
);
    import slcnt_pkg::*;

    logic [ENTRY_W-1:0] old_mem [LIST_DEPTH];
    logic [ENTRY_W-1:0] new_mem [LIST_DEPTH];
    logic [ENTRY_W-1:0] old_q_reg, new_q_reg;

    logic [CNT_W-1:0] old_count_reg, new_count_reg;
    logic [CNT_W-1:0] i_reg, j_reg, i_next, j_next;
    logic [TALLY_W-1:0] tally_reg [T_NUM];
    logic               overflow_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [31:0]         id_wide;
    logic [ENTRY_W-1:0]  entry_in;
    logic                old_full, new_full;
    logic                have_old, have_new;
    logic [ID_WIDTH-1:0] old_id, new_id;
    logic                take_old, take_new, take_both;

    assign id_wide  = 32'(instance_id);
    assign entry_in = {group_one, id_wide[ID_WIDTH-1:0]};
    assign old_full = (old_count_reg == CNT_W'(LIST_DEPTH));
    assign new_full = (new_count_reg == CNT_W'(LIST_DEPTH));

    assign have_old  = (i_reg < old_count_reg);
    assign have_new  = (j_reg < new_count_reg);
    assign old_id    = old_q_reg[ID_WIDTH-1:0];
    assign new_id    = new_q_reg[ID_WIDTH-1:0];
    assign take_new  = have_new && (!have_old || (new_id < old_id));
    assign take_old  = have_old && (!have_new || (new_id > old_id));
    assign take_both = have_old && have_new && (new_id == old_id);

    assign status.walk_done = !have_old && !have_new;
    assign status.out_full  = m_tvalid_reg && !m_tready;

    always_comb begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.merge_start) begin
            i_next = '0;
            j_next = '0;
        end else if (cmd.walk) begin
            i_next = i_reg + CNT_W'(take_old || take_both);
            j_next = j_reg + CNT_W'(take_new || take_both);
        end
    end

    // list storage, registered read at the next walk position
    always_ff @(posedge aclk) begin
        if (cmd.load_old && !old_full) begin
            old_mem[old_count_reg[IDX_W-1:0]] <= entry_in;
        end
        if (cmd.load_new && !new_full) begin
            new_mem[new_count_reg[IDX_W-1:0]] <= entry_in;
        end
        old_q_reg <= old_mem[i_next[IDX_W-1:0]];
        new_q_reg <= new_mem[j_next[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            old_count_reg <= '0;
            new_count_reg <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            overflow_reg  <= 1'b0;
            for (int k = 0; k < T_NUM; k++) begin
                tally_reg[k] <= '0;
            end
        end else begin
            i_reg <= i_next;
            j_reg <= j_next;
            if (cmd.clear) begin
                old_count_reg <= '0;
                new_count_reg <= '0;
                overflow_reg  <= 1'b0;
                for (int k = 0; k < T_NUM; k++) begin
                    tally_reg[k] <= '0;
                end
            end else begin
                if (cmd.load_old) begin
                    if (old_full) begin
                        overflow_reg <= 1'b1;
                    end else begin
                        old_count_reg <= old_count_reg + 1'b1;
                    end
                end
                if (cmd.load_new) begin
                    if (new_full) begin
                        overflow_reg <= 1'b1;
                    end else begin
                        new_count_reg <= new_count_reg + 1'b1;
                    end
                end
                if (cmd.walk_end) begin
                    old_count_reg <= '0;
                    new_count_reg <= '0;
                end
                if (cmd.walk) begin
                    tally_reg[T_TOTAL] <= sat_inc(tally_reg[T_TOTAL], take_old || take_new);
                    tally_reg[T_REM]   <= sat_inc(tally_reg[T_REM], take_old);
                    tally_reg[T_ADD0]  <= sat_inc(tally_reg[T_ADD0],
                                                  take_new && !new_q_reg[ID_WIDTH]);
                    tally_reg[T_ADD1]  <= sat_inc(tally_reg[T_ADD1],
                                                  take_new && new_q_reg[ID_WIDTH]);
                    tally_reg[T_REM0]  <= sat_inc(tally_reg[T_REM0],
                                                  take_old && !old_q_reg[ID_WIDTH]);
                    tally_reg[T_REM1]  <= sat_inc(tally_reg[T_REM1],
                                                  take_old && old_q_reg[ID_WIDTH]);
                end
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            m_tdata_reg <= {7'b0, overflow_reg,
                            tally_reg[T_REM1], tally_reg[T_REM0],
                            tally_reg[T_ADD1], tally_reg[T_ADD0],
                            tally_reg[T_REM], tally_reg[T_TOTAL]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/sorted_list_difference_counter_top.sv -----
// channel | dir | tdata (low bit up)                      | tuser
// --------+-----+-----------------------------------------+-------------
// s_      | in  | instance_id[19:0], group_one[20], pad   | action[1:0]
// m_      | out | diff_total, removals,                   | -
//         |     | additions_group0, additions_group1,     |
//         |     | removals_group0, removals_group1 (32 b  |
//         |     | each), overflow[192], pad               |
//
// Loads never leave the idle state. A clear goes through the done state to its result word.
// A merge is a single-step merge walk over the two list memories (one read each), advancing
// past the lower id, or both on a match, then goes through the done state to its result word.
// aresetn is synchronous; lists need no clearing, counts and tallies reset.
// A pending result word does not stall loads; a merge or clear waits for
// the output register before leaving the busy state.
module sorted_list_difference_counter_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [slcnt_pkg::S_TDATA_W-1:0]     s_tdata,  // instance_id, group_one
    input  logic [slcnt_pkg::ACTION_W-1:0]      s_tuser,  // action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [slcnt_pkg::M_TDATA_W-1:0]     m_tdata   // six tallies, overflow
);
    import slcnt_pkg::*;

    cmd_t    cmd;
    status_t status;
    action_t action;

    assign action = action_t'(s_tuser);

    slcnt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .action   (action),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    slcnt_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .instance_id (s_tdata[IN_ID_W-1:0]),
        .group_one   (s_tdata[IN_ID_W]),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule
